// ===== hdl/cetb_pkg.sv =====
package cetb_pkg;

  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_SNAP   = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  typedef logic [6:0] held_t;
  typedef logic [6:0] snap_t;

  // Largest number of records one snapshot returns.
  localparam snap_t MAX_OUT = 7'd64;

  typedef struct packed {
    logic [31:0]        tick;
    logic [31:0]        seq;
    logic [7:0]         ev;
    logic [7:0]         detail;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } rec_t;

  typedef struct packed {
    logic        found;
    logic        last;
    held_t       held;
    logic [31:0] oldest;
  } meta_t;

endpackage

// ===== hdl/cetb_in_if.sv =====
interface cetb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [31:0]        now_tick;
  logic [7:0]         event_code;
  logic [7:0]         detail_code;
  logic signed [31:0] arg_a;
  logic signed [31:0] arg_b;
  logic signed [31:0] arg_c;
  logic [15:0]        position;
  logic [31:0]        seek_seq;

  modport source (
    output valid, op, now_tick, event_code, detail_code, arg_a, arg_b, arg_c,
           position, seek_seq,
    input  ready
  );
  modport sink (
    input  valid, op, now_tick, event_code, detail_code, arg_a, arg_b, arg_c,
           position, seek_seq,
    output ready
  );
endinterface

// ===== hdl/cetb_out_if.sv =====
interface cetb_out_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic [31:0]        entry_tick;
  logic [31:0]        entry_seq;
  logic [7:0]         entry_event;
  logic [7:0]         entry_detail;
  logic signed [31:0] entry_a;
  logic signed [31:0] entry_b;
  logic signed [31:0] entry_c;
  logic [6:0]         held_count;
  logic [31:0]        oldest_seq;
  logic               last;

  modport source (
    output valid, found, entry_tick, entry_seq, entry_event, entry_detail,
           entry_a, entry_b, entry_c, held_count, oldest_seq, last,
    input  ready
  );
  modport sink (
    input  valid, found, entry_tick, entry_seq, entry_event, entry_detail,
           entry_a, entry_b, entry_c, held_count, oldest_seq, last,
    output ready
  );
endinterface

// ===== hdl/circular_event_trace_buffer.sv =====
// A transaction's result passes through the read stage and then the output register.
// Append, read by offset, find by sequence and clear are one record RAM access each;
// a new transaction can be accepted every cycle while the output is not stalled.
// A snapshot of n records reads the RAM once per record and holds the input off
// until its last read is issued. Reset synchronously clears the counters, head and
// pipeline valids; the record RAM is not cleared, and only held entries are returned.
module circular_event_trace_buffer #(
  parameter int LOG_DEPTH = 64
) (
  input logic       clk,
  input logic       rst_n,
  cetb_in_if.sink   in_ch,
  cetb_out_if.source out_ch
);

  localparam int AW = $clog2(LOG_DEPTH);
  localparam int CW = $clog2(LOG_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_X  = LOG_DEPTH[AW:0];
  localparam logic [AW:0]   ONE_X    = (AW+1)'(1);
  localparam logic [CW-1:0] CNT_FULL = LOG_DEPTH[CW-1:0];

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  // Adds two ring indexes whose sum stays below twice the depth.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW:0] b);
    logic [AW+1:0] s;
    s = {2'b00, a} + {1'b0, b};
    if (s >= {1'b0, DEPTH_X}) begin
      s = s - {1'b0, DEPTH_X};
    end
    return s[AW-1:0];
  endfunction

  logic                state_r, state_nxt;
  logic [AW-1:0]       head_r, head_nxt;
  logic [AW-1:0]       tail_r, tail_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [31:0]         nseq_r, nseq_nxt;
  logic [31:0]         oseq_r, oseq_nxt;
  logic [AW-1:0]       walk_idx_r, walk_idx_nxt;
  cetb_pkg::snap_t     walk_left_r, walk_left_nxt;

  logic                s1_v_r;
  cetb_pkg::meta_t     s1_meta_r;
  logic                out_v_r;
  cetb_pkg::meta_t     out_meta_r;
  cetb_pkg::rec_t      out_rec_r;

  logic                s1_move, issue_ok, acc, full;
  logic                issue, wr_en;
  logic [AW-1:0]       rd_addr;
  cetb_pkg::rec_t      wr_data, rd_data;
  cetb_pkg::meta_t     iss_meta;
  logic                iss_found, iss_last;

  logic [16:0]         pos_x, cnt_x, snap_m;
  cetb_pkg::snap_t     snap_n;
  logic [AW-1:0]       snap_start;
  logic                pos_hit, seek_hit;
  logic [31:0]         seek_d;

  assign s1_move     = s1_v_r && (!out_v_r || out_ch.ready);
  assign issue_ok    = !s1_v_r || s1_move;
  assign in_ch.ready = issue_ok && (state_r == ST_IDLE);
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = (count_r == CNT_FULL);

  assign pos_x   = {1'b0, in_ch.position};
  assign cnt_x   = 17'(count_r);
  assign snap_m  = (pos_x < cnt_x) ? pos_x : cnt_x;
  assign snap_n  = (snap_m > {10'd0, cetb_pkg::MAX_OUT}) ? cetb_pkg::MAX_OUT : snap_m[6:0];
  assign snap_start = wrap_add(head_r, DEPTH_X - (AW+1)'(snap_n));
  assign pos_hit = (pos_x < cnt_x);

  // Held records carry consecutive sequence numbers starting at the oldest one,
  // so a sought number maps straight onto its slot.
  assign seek_d   = in_ch.seek_seq - oseq_r;
  assign seek_hit = (count_r != '0) && (seek_d < 32'(count_r));

  assign wr_data = '{tick:   in_ch.now_tick,
                     seq:    nseq_r,
                     ev:     in_ch.event_code,
                     detail: in_ch.detail_code,
                     a:      in_ch.arg_a,
                     b:      in_ch.arg_b,
                     c:      in_ch.arg_c};

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    nseq_nxt      = nseq_r;
    oseq_nxt      = oseq_r;
    walk_idx_nxt  = walk_idx_r;
    walk_left_nxt = walk_left_r;
    issue         = 1'b0;
    wr_en         = 1'b0;
    rd_addr       = '0;
    iss_found     = 1'b0;
    iss_last      = 1'b1;
    if (state_r == ST_WALK) begin
      if (issue_ok) begin
        issue         = 1'b1;
        iss_found     = 1'b1;
        rd_addr       = walk_idx_r;
        iss_last      = (walk_left_r == 7'd1);
        walk_idx_nxt  = wrap_add(walk_idx_r, ONE_X);
        walk_left_nxt = walk_left_r - 7'd1;
        if (walk_left_r == 7'd1) begin
          state_nxt = ST_IDLE;
        end
      end
    end else if (acc) begin
      issue = 1'b1;
      unique case (in_ch.op)
        cetb_pkg::OP_APPEND: begin
          wr_en    = 1'b1;
          nseq_nxt = nseq_r + 32'd1;
          head_nxt = wrap_add(head_r, ONE_X);
          if (count_r == '0) begin
            oseq_nxt = nseq_r;
          end
          if (full) begin
            tail_nxt = wrap_add(tail_r, ONE_X);
            oseq_nxt = oseq_r + 32'd1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        cetb_pkg::OP_SNAP: begin
          if (snap_n != '0) begin
            iss_found = 1'b1;
            rd_addr   = snap_start;
            iss_last  = (snap_n == 7'd1);
            if (snap_n != 7'd1) begin
              state_nxt     = ST_WALK;
              walk_idx_nxt  = wrap_add(snap_start, ONE_X);
              walk_left_nxt = snap_n - 7'd1;
            end
          end
        end
        cetb_pkg::OP_READ: begin
          if (pos_hit) begin
            iss_found = 1'b1;
            rd_addr   = wrap_add(tail_r, {1'b0, in_ch.position[AW-1:0]});
          end
        end
        cetb_pkg::OP_FIND: begin
          if (seek_hit) begin
            iss_found = 1'b1;
            rd_addr   = wrap_add(tail_r, {1'b0, seek_d[AW-1:0]});
          end
        end
        cetb_pkg::OP_CLEAR: begin
          head_nxt  = '0;
          tail_nxt  = '0;
          count_nxt = '0;
          nseq_nxt  = '0;
          oseq_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
    iss_meta = '{found:  iss_found,
                 last:   iss_last,
                 held:   cetb_pkg::held_t'(count_nxt),
                 oldest: oseq_nxt};
  end

  cetb_ram #(
    .WIDTH ($bits(cetb_pkg::rec_t)),
    .DEPTH (LOG_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_r),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      nseq_r      <= '0;
      oseq_r      <= '0;
      walk_idx_r  <= '0;
      walk_left_r <= '0;
      s1_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      nseq_r      <= nseq_nxt;
      oseq_r      <= oseq_nxt;
      walk_idx_r  <= walk_idx_nxt;
      walk_left_r <= walk_left_nxt;
      if (issue) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
      if (s1_move) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_meta_r <= iss_meta;
    end
    if (s1_move) begin
      out_meta_r <= s1_meta_r;
      out_rec_r  <= s1_meta_r.found ? rd_data : '0;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.found        = out_meta_r.found;
  assign out_ch.entry_tick   = out_rec_r.tick;
  assign out_ch.entry_seq    = out_rec_r.seq;
  assign out_ch.entry_event  = out_rec_r.ev;
  assign out_ch.entry_detail = out_rec_r.detail;
  assign out_ch.entry_a      = out_rec_r.a;
  assign out_ch.entry_b      = out_rec_r.b;
  assign out_ch.entry_c      = out_rec_r.c;
  assign out_ch.held_count   = out_meta_r.held;
  assign out_ch.oldest_seq   = out_meta_r.oldest;
  assign out_ch.last         = out_meta_r.last;

  // While the log is not full, the oldest record sits in slot zero.
  a_ring_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != CNT_FULL) |-> (tail_r == '0 && head_r == AW'(count_r)))
    else $error("ring head or tail out of step with the count");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("record count above depth");

  a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !in_ch.ready)
    else $error("input taken during a snapshot walk");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.op == cetb_pkg::OP_CLEAR) |=> (count_r == '0 && nseq_r == '0))
    else $error("clear left records behind");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_move) |=> (s1_v_r && $stable(s1_meta_r)))
    else $error("read stage lost or changed a stalled transaction");

endmodule

// ===== hdl/cetb_ram.sv =====
module cetb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds while rd_en is low.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
